// File: hdl/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies; the including scope provides clk and rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SLQM_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slqm assertion failed");

// next-cycle implication
`define SLQM_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slqm assertion failed");

`endif

// File: hdl/slqm_pkg.sv
// shared types and codes for the segmented list queue manager
// no dependencies
package slqm_pkg;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_SHIFT = 2'd2,
        OP_PEEK  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NOMEM = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LIST,
        S_META,
        S_FIND_GRP,
        S_FIND_SEG,
        S_ALLOC,
        S_WORDS,
        S_OUT
    } state_t;

    typedef struct packed {
        logic capture;
        logic rd_meta;
        logic apply;
        logic find_grp;
        logic find_seg;
        logic alloc;
        logic rd_words;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic need_seg;
        logic out_free;
    } sts_t;

endpackage

// File: hdl/slqm_ifs.sv
// request and response channel interfaces
// no dependencies
interface slqm_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [2:0]  list_id;
    logic [31:0] data_in;

    modport source (output valid, opcode, list_id, data_in, input ready);
    modport sink   (input valid, opcode, list_id, data_in, output ready);
endinterface

interface slqm_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] front_word;
    logic [31:0] back_word;
    logic        is_empty;
    logic [1:0]  status;

    modport source (output valid, front_word, back_word, is_empty, status, input ready);
    modport sink   (input valid, front_word, back_word, is_empty, status, output ready);
endinterface

// File: hdl/segmented_list_queue_manager.sv
// channel | dir | payload
// req     | in  | opcode, list_id, data_in
// rsp     | out | front_word, back_word, is_empty, status
//
// one request at a time: pop, shift, peek and pushes into a tail segment with room
// go through the list, meta, words and out states to the result register; a push
// that takes a new segment adds a two-step lowest-free search over groups of sixteen
// segments and an alloc state; each waits on a registered list, metadata or word read.
// a new request is taken while the previous result waits in the output register.
// rst_n clears list occupancy and the segment pool at once; no clearing pass.
// top level; depends on slqm_pkg, the channel interfaces, slqm_ctrl and slqm_dp
module segmented_list_queue_manager #(
    parameter int NUM_SEGMENTS = 16,
    parameter int SEG_ELEMS    = 8,
    parameter int NUM_LISTS    = 8,
    parameter int WORD_WIDTH   = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    slqm_req_if.sink   req,
    slqm_rsp_if.source rsp
);
    import slqm_pkg::*;

    cmd_t cmd;
    sts_t sts;

    slqm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    slqm_dp #(
        .NUM_SEGMENTS (NUM_SEGMENTS),
        .SEG_ELEMS    (SEG_ELEMS),
        .NUM_LISTS    (NUM_LISTS),
        .WORD_WIDTH   (WORD_WIDTH)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .sts   (sts)
    );

endmodule

// File: hdl/slqm_ctrl.sv
// sequencer for one queue operation at a time
// depends on slqm_pkg
module slqm_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  slqm_pkg::sts_t sts,
    output slqm_pkg::cmd_t cmd
);
    import slqm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_LIST;
                end
            end
            S_LIST:     state_next = S_META;
            S_META:     state_next = sts.need_seg ? S_FIND_GRP : S_WORDS;
            S_FIND_GRP: state_next = S_FIND_SEG;
            S_FIND_SEG: state_next = S_ALLOC;
            S_ALLOC:    state_next = S_WORDS;
            S_WORDS:    state_next = S_OUT;
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
            end
            S_LIST:     cmd.rd_meta  = 1'b1;
            S_META:     cmd.apply    = 1'b1;
            S_FIND_GRP: cmd.find_grp = 1'b1;
            S_FIND_SEG: cmd.find_seg = 1'b1;
            S_ALLOC:    cmd.alloc    = 1'b1;
            S_WORDS:    cmd.rd_words = 1'b1;
            S_OUT:      cmd.load_out = sts.out_free;
            default:    ;
        endcase
    end

endmodule

// File: hdl/slqm_dp.sv
// datapath: list table, segment metadata and word memories, free search
// depends on slqm_pkg and the channel interfaces
module slqm_dp #(
    parameter int NUM_SEGMENTS = 16,
    parameter int SEG_ELEMS    = 8,
    parameter int NUM_LISTS    = 8,
    parameter int WORD_WIDTH   = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    slqm_req_if.sink       req,
    slqm_rsp_if.source     rsp,
    input  slqm_pkg::cmd_t cmd,
    output slqm_pkg::sts_t sts
);
    import slqm_pkg::*;

    localparam int SW    = $clog2(NUM_SEGMENTS);
    localparam int OW    = (SEG_ELEMS > 1) ? $clog2(SEG_ELEMS) : 1;
    localparam int FW    = $clog2(SEG_ELEMS + 1);
    localparam int LW    = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
    localparam int DEPTH = NUM_SEGMENTS * SEG_ELEMS;
    localparam int AW    = $clog2(DEPTH);
    localparam int NG    = (NUM_SEGMENTS + 15) / 16;
    localparam int GW    = (NG > 1) ? $clog2(NG) : 1;
    localparam logic [OW:0]   E_O = (OW + 1)'(SEG_ELEMS);
    localparam logic [FW-1:0] E_F = FW'(SEG_ELEMS);
    localparam logic [AW-1:0] E_A = AW'(SEG_ELEMS);

    typedef struct packed {
        logic [SW-1:0] head;
        logic [SW-1:0] tail;
    } list_ent_t;

    function automatic logic [OW-1:0] wrap_off(input logic [OW:0] sum);
        logic [OW:0] r;
        r = (sum >= E_O) ? (sum - E_O) : sum;
        return r[OW-1:0];
    endfunction

    function automatic logic [AW-1:0] word_addr(input logic [SW-1:0] seg,
                                                 input logic [OW-1:0] off);
        return AW'(seg) * E_A + AW'(off);
    endfunction

    // captured request
    opcode_t               op_reg;
    logic [LW-1:0]         lid_reg;
    logic                  oor_reg;
    logic [WORD_WIDTH-1:0] data_reg;
    logic [31:0]           lid_ext;
    logic [63:0]           data_ext;

    // list table
    list_ent_t             list_mem [NUM_LISTS];
    list_ent_t             list_rd_reg;
    logic [NUM_LISTS-1:0]  ne_reg;
    logic                  ne_rd_reg;

    // segment metadata
    logic [FW-1:0]         fill_mem  [NUM_SEGMENTS];
    logic [OW-1:0]         start_mem [NUM_SEGMENTS];
    logic [SW-1:0]         next_mem  [NUM_SEGMENTS];
    logic [SW-1:0]         prev_mem  [NUM_SEGMENTS];
    logic [FW-1:0]         tfill_rd_reg, hfill_rd_reg;
    logic [OW-1:0]         tstart_rd_reg, hstart_rd_reg;
    logic [SW-1:0]         hnext_rd_reg, tprev_rd_reg;
    logic [NUM_SEGMENTS-1:0] in_use_reg;

    // words
    logic [WORD_WIDTH-1:0] word_mem [DEPTH];
    logic [WORD_WIDTH-1:0] front_rd_reg, back_rd_reg;

    // free search
    logic [NG*16-1:0]      pad;
    logic [NG-1:0]         grp_free;
    logic [GW-1:0]         grp_reg, grp_next;
    logic                  grp_any_reg;
    logic [15:0]           grp_bits;
    logic [3:0]            bit_next;
    logic [SW-1:0]         seg_free_reg;
    logic                  seg_ok_reg;
    logic [31:0]           seg_calc;

    // state after the operation
    logic                  pne_reg, pne_next;
    logic [SW-1:0]         phead_reg, phead_next, ptail_reg, ptail_next;
    logic [OW-1:0]         phstart_reg, phstart_next, ptstart_reg, ptstart_next;
    logic [FW-1:0]         ptfill_reg, ptfill_next;
    status_t               st_reg, st_next;
    logic                  post_load;

    // write ports
    logic                  list_we;
    list_ent_t             list_wd;
    logic                  ne_we, ne_wd;
    logic                  fill_we, start_we, next_we, prev_we, word_we, use_we, use_wd;
    logic [SW-1:0]         fill_wa, start_wa, next_wa, prev_wa, use_wa, next_wd, prev_wd;
    logic [FW-1:0]         fill_wd;
    logic [OW-1:0]         start_wd;
    logic [AW-1:0]         word_wa;
    logic [WORD_WIDTH-1:0] word_wd;

    logic [SW-1:0]         h, t;
    logic [OW-1:0]         push_off, shift_start, back_off;

    // output register
    logic                  out_valid_reg;
    logic [31:0]           front_out_reg, back_out_reg;
    logic                  empty_out_reg;
    status_t               status_out_reg;
    logic [63:0]           front_ext, back_ext;

    assign lid_ext  = 32'(req.list_id);
    assign data_ext = 64'(req.data_in);
    assign h        = list_rd_reg.head;
    assign t        = list_rd_reg.tail;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg      <= opcode_t'(req.opcode);
            lid_reg     <= lid_ext[LW-1:0];
            oor_reg     <= (lid_ext >= 32'(NUM_LISTS));
            data_reg    <= data_ext[WORD_WIDTH-1:0];
            list_rd_reg <= list_mem[lid_ext[LW-1:0]];
            ne_rd_reg   <= ne_reg[lid_ext[LW-1:0]];
        end
        if (list_we)
        begin
            list_mem[lid_reg] <= list_wd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ne_reg     <= '0;
            in_use_reg <= '0;
        end
        else
        begin
            if (ne_we)
            begin
                ne_reg[lid_reg] <= ne_wd;
            end
            if (use_we)
            begin
                in_use_reg[use_wa] <= use_wd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_meta)
        begin
            tfill_rd_reg  <= fill_mem[t];
            hfill_rd_reg  <= fill_mem[h];
            tstart_rd_reg <= start_mem[t];
            hstart_rd_reg <= start_mem[h];
            hnext_rd_reg  <= next_mem[h];
            tprev_rd_reg  <= prev_mem[t];
        end
        if (fill_we)
        begin
            fill_mem[fill_wa] <= fill_wd;
        end
        if (start_we)
        begin
            start_mem[start_wa] <= start_wd;
        end
        if (next_we)
        begin
            next_mem[next_wa] <= next_wd;
        end
        if (prev_we)
        begin
            prev_mem[prev_wa] <= prev_wd;
        end
    end

    // lowest free segment: first a group of sixteen, then the bit within it
    always_comb
    begin
        pad                    = '1;
        pad[NUM_SEGMENTS-1:0]  = in_use_reg;
        for (int g = 0; g < NG; g++)
        begin
            grp_free[g] = ~&pad[g*16 +: 16];
        end
        grp_next = '0;
        for (int g = NG - 1; g >= 0; g--)
        begin
            if (grp_free[g])
            begin
                grp_next = GW'(g);
            end
        end
        grp_bits = ~pad[grp_reg*16 +: 16];
        bit_next = '0;
        for (int b = 15; b >= 0; b--)
        begin
            if (grp_bits[b])
            begin
                bit_next = 4'(b);
            end
        end
        seg_calc = 32'(grp_reg) * 32'd16 + 32'(bit_next);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.find_grp)
        begin
            grp_reg     <= grp_next;
            grp_any_reg <= |grp_free;
        end
        if (cmd.find_seg)
        begin
            seg_free_reg <= seg_calc[SW-1:0];
            seg_ok_reg   <= grp_any_reg;
        end
    end

    assign sts.need_seg = !oor_reg && (op_reg == OP_PUSH) && (!ne_rd_reg || tfill_rd_reg == E_F);

    always_comb
    begin
        push_off    = wrap_off({1'b0, tstart_rd_reg} + (OW + 1)'(tfill_rd_reg));
        shift_start = wrap_off({1'b0, hstart_rd_reg} + (OW + 1)'(1));

        pne_next     = ne_rd_reg;
        phead_next   = h;
        ptail_next   = t;
        phstart_next = hstart_rd_reg;
        ptstart_next = tstart_rd_reg;
        ptfill_next  = tfill_rd_reg;
        st_next      = ST_OK;
        post_load    = 1'b0;

        list_we  = 1'b0;
        list_wd  = list_rd_reg;
        ne_we    = 1'b0;
        ne_wd    = 1'b0;
        fill_we  = 1'b0;
        fill_wa  = t;
        fill_wd  = '0;
        start_we = 1'b0;
        start_wa = h;
        start_wd = '0;
        next_we  = 1'b0;
        next_wa  = t;
        next_wd  = seg_free_reg;
        prev_we  = 1'b0;
        prev_wa  = seg_free_reg;
        prev_wd  = t;
        word_we  = 1'b0;
        word_wa  = word_addr(t, push_off);
        word_wd  = data_reg;
        use_we   = 1'b0;
        use_wa   = t;
        use_wd   = 1'b0;

        if (cmd.apply && !sts.need_seg)
        begin
            post_load = 1'b1;
            if (oor_reg)
            begin
                pne_next = 1'b0;
            end
            else
            begin
                case (op_reg)
                    OP_PUSH:
                    begin
                        word_we     = 1'b1;
                        fill_we     = 1'b1;
                        fill_wd     = tfill_rd_reg + FW'(1);
                        ptfill_next = tfill_rd_reg + FW'(1);
                    end
                    OP_POP:
                    begin
                        if (!ne_rd_reg)
                        begin
                            st_next = ST_EMPTY;
                        end
                        else if (tfill_rd_reg != FW'(1))
                        begin
                            fill_we     = 1'b1;
                            fill_wd     = tfill_rd_reg - FW'(1);
                            ptfill_next = tfill_rd_reg - FW'(1);
                        end
                        else
                        begin
                            use_we = 1'b1;
                            if (t == h)
                            begin
                                ne_we    = 1'b1;
                                pne_next = 1'b0;
                            end
                            else
                            begin
                                // previous segment becomes the tail; only the head can be
                                // partly drained
                                list_we      = 1'b1;
                                list_wd.tail = tprev_rd_reg;
                                ptail_next   = tprev_rd_reg;
                                ptfill_next  = (tprev_rd_reg == h) ? hfill_rd_reg : E_F;
                                ptstart_next = (tprev_rd_reg == h) ? hstart_rd_reg : '0;
                            end
                        end
                    end
                    OP_SHIFT:
                    begin
                        if (!ne_rd_reg)
                        begin
                            st_next = ST_EMPTY;
                        end
                        else if (hfill_rd_reg != FW'(1))
                        begin
                            // head segment is a ring: advance its start
                            fill_we      = 1'b1;
                            fill_wa      = h;
                            fill_wd      = hfill_rd_reg - FW'(1);
                            start_we     = 1'b1;
                            start_wd     = shift_start;
                            phstart_next = shift_start;
                            if (h == t)
                            begin
                                ptfill_next  = hfill_rd_reg - FW'(1);
                                ptstart_next = shift_start;
                            end
                        end
                        else
                        begin
                            use_we = 1'b1;
                            use_wa = h;
                            if (h == t)
                            begin
                                ne_we    = 1'b1;
                                pne_next = 1'b0;
                            end
                            else
                            begin
                                // a segment that was never head starts at zero
                                list_we      = 1'b1;
                                list_wd.head = hnext_rd_reg;
                                phead_next   = hnext_rd_reg;
                                phstart_next = '0;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end

        if (cmd.alloc)
        begin
            post_load = 1'b1;
            if (!seg_ok_reg)
            begin
                st_next = ST_NOMEM;
            end
            else
            begin
                use_we       = 1'b1;
                use_wa       = seg_free_reg;
                use_wd       = 1'b1;
                fill_we      = 1'b1;
                fill_wa      = seg_free_reg;
                fill_wd      = FW'(1);
                start_we     = 1'b1;
                start_wa     = seg_free_reg;
                start_wd     = '0;
                word_we      = 1'b1;
                word_wa      = word_addr(seg_free_reg, '0);
                list_we      = 1'b1;
                ptail_next   = seg_free_reg;
                ptfill_next  = FW'(1);
                ptstart_next = '0;
                if (ne_rd_reg)
                begin
                    prev_we      = 1'b1;
                    next_we      = 1'b1;
                    list_wd.tail = seg_free_reg;
                end
                else
                begin
                    ne_we        = 1'b1;
                    ne_wd        = 1'b1;
                    pne_next     = 1'b1;
                    list_wd.head = seg_free_reg;
                    list_wd.tail = seg_free_reg;
                    phead_next   = seg_free_reg;
                    phstart_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (post_load)
        begin
            pne_reg     <= pne_next;
            phead_reg   <= phead_next;
            ptail_reg   <= ptail_next;
            phstart_reg <= phstart_next;
            ptstart_reg <= ptstart_next;
            ptfill_reg  <= ptfill_next;
            st_reg      <= st_next;
        end
    end

    assign back_off = wrap_off({1'b0, ptstart_reg} + (OW + 1)'(ptfill_reg) - (OW + 1)'(1));

    always_ff @(posedge clk)
    begin
        if (word_we)
        begin
            word_mem[word_wa] <= word_wd;
        end
        if (cmd.rd_words)
        begin
            front_rd_reg <= word_mem[word_addr(phead_reg, phstart_reg)];
            back_rd_reg  <= word_mem[word_addr(ptail_reg, back_off)];
        end
    end

    assign front_ext    = 64'(front_rd_reg);
    assign back_ext     = 64'(back_rd_reg);
    assign sts.out_free = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            front_out_reg  <= pne_reg ? front_ext[31:0] : 32'd0;
            back_out_reg   <= pne_reg ? back_ext[31:0] : 32'd0;
            empty_out_reg  <= !pne_reg;
            status_out_reg <= st_reg;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.front_word = front_out_reg;
    assign rsp.back_word  = back_out_reg;
    assign rsp.is_empty   = empty_out_reg;
    assign rsp.status     = status_out_reg;

endmodule

// File: hdl/slqm_checker.sv
// port-level checks for the queue manager, bound to the top level
// depends on slqm_pkg and assert_macros.svh
`include "assert_macros.svh"

module slqm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [31:0] front_word,
    input logic [31:0] back_word,
    input logic        is_empty,
    input logic [1:0]  status
);
    import slqm_pkg::*;

    logic [1:0] pending_reg;
    logic [1:0] pending_next;

    // requests taken whose result has not yet been taken
    always_comb
    begin
        pending_next = pending_reg;
        if (req_valid && req_ready && !(rsp_valid && rsp_ready))
        begin
            pending_next = pending_reg + 2'd1;
        end
        else if (!(req_valid && req_ready) && rsp_valid && rsp_ready)
        begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `SLQM_ASSERT_NEXT(a_rsp_held, rsp_valid && !rsp_ready, rsp_valid)
    `SLQM_ASSERT_IMPL(a_rsp_has_req, rsp_valid, pending_reg != 2'd0)
    `SLQM_ASSERT_IMPL(a_pending_bound, 1'b1, pending_reg != 2'd3)
    `SLQM_ASSERT_IMPL(a_empty_zero, rsp_valid && is_empty, front_word == 32'd0 && back_word == 32'd0)
    `SLQM_ASSERT_IMPL(a_status_code, rsp_valid, status == ST_OK || status == ST_NOMEM || status == ST_EMPTY)

endmodule

bind segmented_list_queue_manager slqm_checker u_slqm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .front_word (rsp.front_word),
    .back_word  (rsp.back_word),
    .is_empty   (rsp.is_empty),
    .status     (rsp.status)
);
